[rtl/core/teabd_pkg.sv]
package teabd_pkg;

    localparam int NUM_ROUNDS = 32;
    localparam int NUM_STAGES = 2 * NUM_ROUNDS;
    localparam int WORD_W     = 32;
    localparam int KEY_IDX_W  = 2;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t TEA_DELTA = 32'h9E37_79B9;

    typedef enum logic [KEY_IDX_W-1:0] {
        KEY_W0 = 2'd0,
        KEY_W1 = 2'd1,
        KEY_W2 = 2'd2,
        KEY_W3 = 2'd3
    } key_idx_t;

    typedef struct packed {
        word_t k_a;
        word_t k_b;
    } key_pair_t;

    // sum used in a given round, counted from the first decryption round
    function automatic word_t round_sum(input int round);
        logic [2*WORD_W-1:0] prod;
        prod = (2*WORD_W)'(TEA_DELTA) * (2*WORD_W)'(NUM_ROUNDS - round);
        return prod[WORD_W-1:0];
    endfunction

    function automatic word_t mix_word(input word_t w, input word_t sum,
                                       input word_t ka, input word_t kb);
        word_t a;
        word_t b;
        word_t c;
        a = (w << 4) + ka;
        b = w + sum;
        c = (w >> 5) + kb;
        return a ^ b ^ c;
    endfunction

endpackage

[rtl/core/teabd_key_regs.sv]
module teabd_key_regs
    import teabd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [KEY_IDX_W-1:0] cfg_index,
    input  word_t                cfg_data,
    output key_pair_t            key_lo,
    output key_pair_t            key_hi
);

    word_t key0_reg;
    word_t key1_reg;
    word_t key2_reg;
    word_t key3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (key_idx_t'(cfg_index))
                KEY_W0:  key0_reg <= cfg_data;
                KEY_W1:  key1_reg <= cfg_data;
                KEY_W2:  key2_reg <= cfg_data;
                KEY_W3:  key3_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign key_lo = '{k_a: key0_reg, k_b: key1_reg};
    assign key_hi = '{k_a: key2_reg, k_b: key3_reg};

endmodule

[rtl/core/teabd_stage.sv]
module teabd_stage
    import teabd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      valid_in,
    input  word_t     source_in,
    input  word_t     target_in,
    input  word_t     sum,
    input  key_pair_t keys,
    output logic      valid_out,
    output word_t     source_out,
    output word_t     target_out
);

    logic  valid_reg;
    word_t source_reg;
    word_t target_reg;
    word_t target_next;

    // half round: target word loses the mix of the source word
    assign target_next = target_in - mix_word(source_in, sum, keys.k_a, keys.k_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        source_reg <= source_in;
        target_reg <= target_next;
    end

    assign valid_out  = valid_reg;
    assign source_out = source_reg;
    assign target_out = target_reg;

    a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (valid_reg == $past(valid_in)))
        else $error("stage valid lost or invented");

    a_source_kept: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n) && valid_reg) |-> (source_reg == $past(source_in)))
        else $error("stage source word altered");

    a_target_inverts: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n) && valid_reg) |->
        (target_reg + mix_word(source_reg, $past(sum), $past(keys.k_a), $past(keys.k_b))
            == $past(target_in)))
        else $error("stage target word wrong");

endmodule

[rtl/core/tea_block_decrypt.sv]
// channel  | handshake        | payload
// ---------+------------------+-----------------------------------------
// cipher   | start, busy      | cipher_left, cipher_right
// plain    | done             | plain_left, plain_right
// key cfg  | cfg_write        | cfg_index, cfg_data
//
// one half round per stage, 2 * NUM_ROUNDS registered stages between the cipher and plain ports
// busy stays low, a new beat can enter on every cycle
// rst_n clears all stage valid bits and the key words
// the receiver cannot stall: done is a one-cycle strobe
module tea_block_decrypt
    import teabd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  word_t                cipher_left,
    input  word_t                cipher_right,
    output logic                 done,
    output word_t                plain_left,
    output word_t                plain_right,
    input  logic                 cfg_write,
    input  logic [KEY_IDX_W-1:0] cfg_index,
    input  word_t                cfg_data
);

    key_pair_t key_lo;
    key_pair_t key_hi;

    logic  stage_valid [0:NUM_STAGES];
    word_t stage_left  [0:NUM_STAGES];
    word_t stage_right [0:NUM_STAGES];

    teabd_key_regs u_key_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_lo    (key_lo),
        .key_hi    (key_hi)
    );

    assign busy           = 1'b0;
    assign stage_valid[0] = start && !busy;
    assign stage_left[0]  = cipher_left;
    assign stage_right[0] = cipher_right;

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        localparam word_t ROUND_SUM = round_sum(s / 2);
        if ((s % 2) == 0)
        begin : g_right
            teabd_stage u_stage (
                .clk        (clk),
                .rst_n      (rst_n),
                .valid_in   (stage_valid[s]),
                .source_in  (stage_left[s]),
                .target_in  (stage_right[s]),
                .sum        (ROUND_SUM),
                .keys       (key_hi),
                .valid_out  (stage_valid[s+1]),
                .source_out (stage_left[s+1]),
                .target_out (stage_right[s+1])
            );
        end
        else
        begin : g_left
            teabd_stage u_stage (
                .clk        (clk),
                .rst_n      (rst_n),
                .valid_in   (stage_valid[s]),
                .source_in  (stage_right[s]),
                .target_in  (stage_left[s]),
                .sum        (ROUND_SUM),
                .keys       (key_lo),
                .valid_out  (stage_valid[s+1]),
                .source_out (stage_right[s+1]),
                .target_out (stage_left[s+1])
            );
        end
    end

    assign done        = stage_valid[NUM_STAGES];
    assign plain_left  = stage_left[NUM_STAGES];
    assign plain_right = stage_right[NUM_STAGES];

endmodule
